[rtl/core/isp_memory_frame_sequencer_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the memory frame sequencer
// ---------------------------------------------------------------------------
`ifndef ISP_MEMORY_FRAME_SEQUENCER_UNIT_DEFINES_SVH
`define ISP_MEMORY_FRAME_SEQUENCER_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define IMSQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define IMSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/imsq_pkg.sv]
// ---------------------------------------------------------------------------
// imsq_pkg
// Types, codes and constants shared by the memory frame sequencer.
// ---------------------------------------------------------------------------
package imsq_pkg;

    // Default address width
    localparam int ADDR_BITS_DEF = 16;

    // Opcode bit that selects the high byte of a flash word
    localparam logic [7:0] HIGH_OP_BIT     = 8'h08;
    // Data value that cannot be polled, and its fixed wait
    localparam logic [7:0] FF_BYTE         = 8'hFF;
    localparam logic [7:0] FF_BYTE_WAIT    = 8'd9;
    // Minimum waits after a write
    localparam logic [7:0] FLASH_MIN_WAIT  = 8'd5;
    localparam logic [7:0] EEPROM_MIN_WAIT = 8'd4;

    // Request codes
    typedef enum logic [2:0] {
        ACT_SET_ADDR     = 3'd0,
        ACT_READ_BYTE    = 3'd1,
        ACT_READ_WORD    = 3'd2,
        ACT_LOAD_WORD    = 3'd3,
        ACT_COMMIT_FLASH = 3'd4,
        ACT_EEPROM_BYTE  = 3'd5,
        ACT_COMMIT_EE    = 3'd6,
        ACT_REPLY        = 3'd7
    } t_action;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_WAIT  = 2'd1,
        KIND_DATA  = 2'd2
    } t_kind;

    // EEPROM write modes
    typedef enum logic [1:0] {
        EE_PAGE   = 2'd0,
        EE_TIMED  = 2'd1,
        EE_POLLED = 2'd2,
        EE_NOWAIT = 2'd3
    } t_ee_mode;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_READ_OPCODE   = 3'd0,
        CFG_LOAD_OPCODE   = 3'd1,
        CFG_COMMIT_OPCODE = 3'd2,
        CFG_POLL_OPCODE   = 3'd3,
        CFG_POLL_BUSY     = 3'd4,
        CFG_PAGE_MASK     = 3'd5,
        CFG_EEPROM_MODE   = 3'd6,
        CFG_WRITE_DELAY   = 3'd7
    } t_cfg_index;

    // Configuration register set
    typedef struct packed {
        logic [7:0] read_opcode;
        logic [7:0] load_opcode;
        logic [7:0] commit_opcode;
        logic [7:0] poll_opcode;
        logic [7:0] poll_busy_value;
        logic [7:0] page_mask;
        t_ee_mode   eeprom_mode;
        logic [7:0] write_delay_ms;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        read_opcode:     8'h20,
        load_opcode:     8'h40,
        commit_opcode:   8'h4C,
        poll_opcode:     8'hA0,
        poll_busy_value: 8'hFF,
        page_mask:       8'h3F,
        eeprom_mode:     EE_PAGE,
        write_delay_ms:  8'd5
    };

    // One result item
    typedef struct packed {
        t_kind      kind;
        logic [7:0] frame_byte0;
        logic [7:0] frame_byte1;
        logic [7:0] frame_byte2;
        logic [7:0] frame_byte3;
        logic [7:0] wait_ms;
        logic [7:0] read_data;
        logic       last;
    } t_result;

    // Build a serial frame result
    function automatic t_result mk_frame(logic [7:0] b0, logic [7:0] b1,
                                         logic [7:0] b2, logic [7:0] b3);
        t_result r;
        r             = '0;
        r.kind        = KIND_FRAME;
        r.frame_byte0 = b0;
        r.frame_byte1 = b1;
        r.frame_byte2 = b2;
        r.frame_byte3 = b3;
        return r;
    endfunction

    // Build a wait request result
    function automatic t_result mk_wait(logic [7:0] ms);
        t_result r;
        r         = '0;
        r.kind    = KIND_WAIT;
        r.wait_ms = ms;
        return r;
    endfunction

    // Build a read data result
    function automatic t_result mk_data(logic [7:0] v);
        t_result r;
        r           = '0;
        r.kind      = KIND_DATA;
        r.read_data = v;
        return r;
    endfunction

    // Larger of a requested wait and a minimum
    function automatic logic [7:0] at_least(logic [7:0] v, logic [7:0] m);
        return (v < m) ? m : v;
    endfunction

endpackage

[rtl/core/imsq_frame_gen.sv]
// ---------------------------------------------------------------------------
// imsq_frame_gen
// Forms the results of one request and the next sequencer state.
// ---------------------------------------------------------------------------
module imsq_frame_gen #(
    parameter int ADDR_BITS = imsq_pkg::ADDR_BITS_DEF
) (
    input  logic [2:0]           i_action,
    input  logic [15:0]          i_address,
    input  logic [7:0]           i_data_low,
    input  logic [7:0]           i_data_high,
    input  logic [7:0]           i_reply_byte,
    input  logic                 i_first_of_command,
    input  imsq_pkg::t_cfg       i_cfg,
    input  logic [ADDR_BITS-1:0] i_base,
    input  logic [ADDR_BITS-1:0] i_cur,
    input  logic                 i_polling,
    input  logic [ADDR_BITS-1:0] i_poll_addr,
    input  logic [7:0]           i_poll_data,
    output imsq_pkg::t_result    o_res0,
    output imsq_pkg::t_result    o_res1,
    output logic [1:0]           o_count,
    output logic [ADDR_BITS-1:0] o_base,
    output logic [ADDR_BITS-1:0] o_cur,
    output logic                 o_polling,
    output logic [ADDR_BITS-1:0] o_poll_addr,
    output logic [7:0]           o_poll_data
);
    import imsq_pkg::*;

    t_action              act;
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] addr_inc;
    logic [15:0]          a16;
    logic [15:0]          b16;
    logic [15:0]          p16;
    logic [7:0]           lo_in;
    logic [7:0]           base_lo_out;
    logic [7:0]           flash_wait;
    logic [7:0]           ee_wait;
    t_result              res0;
    t_result              res1;
    logic [1:0]           cnt;

    // Select the working address and its byte views
    always_comb begin
        act         = t_action'(i_action);
        addr        = i_first_of_command ? i_base : i_cur;
        addr_inc    = addr + ADDR_BITS'(1);
        a16         = 16'(addr);
        b16         = 16'(i_base);
        p16         = 16'(i_poll_addr);
        lo_in       = a16[7:0] & i_cfg.page_mask;
        base_lo_out = b16[7:0] & ~i_cfg.page_mask;
        flash_wait  = at_least(i_cfg.write_delay_ms, FLASH_MIN_WAIT);
        ee_wait     = at_least(i_cfg.write_delay_ms, EEPROM_MIN_WAIT);
    end

    // Decode the request into results and state updates
    always_comb begin
        res0        = '0;
        res1        = '0;
        cnt         = 2'd0;
        o_base      = i_base;
        o_cur       = i_cur;
        o_polling   = 1'b0;
        o_poll_addr = i_poll_addr;
        o_poll_data = i_poll_data;

        case (act)
            ACT_REPLY: begin
                o_cur = i_cur;
                if (i_polling) begin
                    if (i_reply_byte == i_cfg.poll_busy_value) begin
                        res0      = mk_frame(i_cfg.poll_opcode, p16[15:8], p16[7:0],
                                             i_poll_data);
                        cnt       = 2'd1;
                        o_polling = 1'b1;
                    end
                end else begin
                    res0 = mk_data(i_reply_byte);
                    cnt  = 2'd1;
                end
            end
            ACT_SET_ADDR: begin
                o_base = i_address[ADDR_BITS-1:0];
                o_cur  = i_address[ADDR_BITS-1:0];
            end
            ACT_READ_BYTE: begin
                res0  = mk_frame(i_cfg.read_opcode, a16[15:8], a16[7:0], 8'h00);
                cnt   = 2'd1;
                o_cur = addr_inc;
            end
            ACT_READ_WORD: begin
                res0  = mk_frame(i_cfg.read_opcode, a16[15:8], a16[7:0], 8'h00);
                res1  = mk_frame(i_cfg.read_opcode | HIGH_OP_BIT, a16[15:8], a16[7:0],
                                 8'h00);
                cnt   = 2'd2;
                o_cur = addr_inc;
            end
            ACT_LOAD_WORD: begin
                res0  = mk_frame(i_cfg.load_opcode, a16[15:8], lo_in, i_data_low);
                res1  = mk_frame(i_cfg.load_opcode | HIGH_OP_BIT, a16[15:8], lo_in,
                                 i_data_high);
                cnt   = 2'd2;
                o_cur = addr_inc;
            end
            ACT_COMMIT_FLASH: begin
                res0  = mk_frame(i_cfg.commit_opcode, b16[15:8], base_lo_out, 8'h00);
                res1  = mk_wait(flash_wait);
                cnt   = 2'd2;
                o_cur = addr;
            end
            ACT_EEPROM_BYTE: begin
                o_cur = addr_inc;
                case (i_cfg.eeprom_mode)
                    EE_PAGE: begin
                        res0 = mk_frame(i_cfg.load_opcode, 8'h00, lo_in, i_data_low);
                        cnt  = 2'd1;
                    end
                    EE_TIMED: begin
                        res0 = mk_frame(i_cfg.load_opcode, a16[15:8], a16[7:0],
                                        i_data_low);
                        res1 = mk_wait(ee_wait);
                        cnt  = 2'd2;
                    end
                    EE_POLLED: begin
                        res0 = mk_frame(i_cfg.load_opcode, a16[15:8], a16[7:0],
                                        i_data_low);
                        cnt  = 2'd2;
                        if (i_data_low == FF_BYTE) begin
                            res1 = mk_wait(FF_BYTE_WAIT);
                        end else begin
                            res1        = mk_frame(i_cfg.poll_opcode, a16[15:8],
                                                   a16[7:0], i_data_low);
                            o_polling   = 1'b1;
                            o_poll_addr = addr;
                            o_poll_data = i_data_low;
                        end
                    end
                    default: begin
                        res0 = mk_frame(i_cfg.load_opcode, a16[15:8], a16[7:0],
                                        i_data_low);
                        cnt  = 2'd1;
                    end
                endcase
            end
            default: begin
                // Commit EEPROM page; other modes ignore it
                o_cur = addr;
                if (i_cfg.eeprom_mode == EE_PAGE) begin
                    res0 = mk_frame(i_cfg.commit_opcode, b16[15:8], base_lo_out, 8'h00);
                    res1 = mk_wait(ee_wait);
                    cnt  = 2'd2;
                end
            end
        endcase

        // Mark the final result
        if (cnt == 2'd2) begin
            res1.last = 1'b1;
        end else if (cnt == 2'd1) begin
            res0.last = 1'b1;
        end
    end

    assign o_res0  = res0;
    assign o_res1  = res1;
    assign o_count = cnt;

endmodule

[rtl/core/isp_memory_frame_sequencer_unit.sv]
// ---------------------------------------------------------------------------
// isp_memory_frame_sequencer_unit
// Turns memory-programming requests into serial programming frames.
// ---------------------------------------------------------------------------
// Each accepted request is decoded in the cycle of its transfer and its zero,
// one or two results land in a two-entry result buffer; the sequencer state
// (base, current and poll address, poll data, polling flag) updates at the
// same edge. The result port delivers one result per cycle unless stalled,
// so a request with one result or none can be taken every cycle; one with
// two results stalls the next until its first result leaves (single output
// port). A request is taken while the last buffered result leaves in the
// same cycle. Configuration writes are always ready and are registered.
`include "isp_memory_frame_sequencer_unit_defines.svh"

module isp_memory_frame_sequencer_unit #(
    parameter int ADDR_BITS = imsq_pkg::ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data_low,
    input  logic [7:0]  i_data_high,
    input  logic [7:0]  i_reply_byte,
    input  logic        i_first_of_command,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_frame_byte0,
    output logic [7:0]  o_frame_byte1,
    output logic [7:0]  o_frame_byte2,
    output logic [7:0]  o_frame_byte3,
    output logic [7:0]  o_wait_ms,
    output logic [7:0]  o_read_data,
    output logic        o_last
);
    import imsq_pkg::*;

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic [ADDR_BITS-1:0] r_base;
    logic [ADDR_BITS-1:0] r_cur;
    logic                 r_polling;
    logic [ADDR_BITS-1:0] r_poll_addr;
    logic [7:0]           r_poll_data;
    logic [1:0]           r_cnt;
    logic [1:0]           n_cnt;
    t_result              r_res0;
    t_result              r_res1;
    t_result              n_res0;
    t_result              n_res1;

    logic                 in_acc;
    logic                 out_acc;
    t_result              gen_res0;
    t_result              gen_res1;
    logic [1:0]           gen_cnt;
    logic [ADDR_BITS-1:0] gen_base;
    logic [ADDR_BITS-1:0] gen_cur;
    logic                 gen_polling;
    logic [ADDR_BITS-1:0] gen_poll_addr;
    logic [7:0]           gen_poll_data;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_cnt != 2'd0);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_in_stall  = !((r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_out_stall));
    assign in_acc      = i_in_valid && !o_in_stall;

    // Decode the request
    imsq_frame_gen #(
        .ADDR_BITS (ADDR_BITS)
    ) u_gen (
        .i_action           (i_action),
        .i_address          (i_address),
        .i_data_low         (i_data_low),
        .i_data_high        (i_data_high),
        .i_reply_byte       (i_reply_byte),
        .i_first_of_command (i_first_of_command),
        .i_cfg              (r_cfg),
        .i_base             (r_base),
        .i_cur              (r_cur),
        .i_polling          (r_polling),
        .i_poll_addr        (r_poll_addr),
        .i_poll_data        (r_poll_data),
        .o_res0             (gen_res0),
        .o_res1             (gen_res1),
        .o_count            (gen_cnt),
        .o_base             (gen_base),
        .o_cur              (gen_cur),
        .o_polling          (gen_polling),
        .o_poll_addr        (gen_poll_addr),
        .o_poll_data        (gen_poll_data)
    );

    // Apply a configuration write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_READ_OPCODE:   n_cfg.read_opcode     = i_cfg_data;
                CFG_LOAD_OPCODE:   n_cfg.load_opcode     = i_cfg_data;
                CFG_COMMIT_OPCODE: n_cfg.commit_opcode   = i_cfg_data;
                CFG_POLL_OPCODE:   n_cfg.poll_opcode     = i_cfg_data;
                CFG_POLL_BUSY:     n_cfg.poll_busy_value = i_cfg_data;
                CFG_PAGE_MASK:     n_cfg.page_mask       = i_cfg_data;
                CFG_EEPROM_MODE:   n_cfg.eeprom_mode     = t_ee_mode'(i_cfg_data[1:0]);
                CFG_WRITE_DELAY:   n_cfg.write_delay_ms  = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    // Drain the result buffer and load new results
    always_comb begin
        n_cnt  = r_cnt;
        n_res0 = r_res0;
        n_res1 = r_res1;
        if (out_acc) begin
            if (r_cnt == 2'd2) begin
                n_res0 = r_res1;
                n_cnt  = 2'd1;
            end else begin
                n_cnt = 2'd0;
            end
        end
        if (in_acc) begin
            n_res0 = gen_res0;
            n_res1 = gen_res1;
            n_cnt  = gen_cnt;
        end
    end

    // Control and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_cnt       <= 2'd0;
            r_base      <= '0;
            r_cur       <= '0;
            r_polling   <= 1'b0;
            r_poll_addr <= '0;
            r_poll_data <= 8'h00;
        end else begin
            r_cfg <= n_cfg;
            r_cnt <= n_cnt;
            if (in_acc) begin
                r_base      <= gen_base;
                r_cur       <= gen_cur;
                r_polling   <= gen_polling;
                r_poll_addr <= gen_poll_addr;
                r_poll_data <= gen_poll_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

    // Present the head of the buffer
    assign o_kind        = r_res0.kind;
    assign o_frame_byte0 = r_res0.frame_byte0;
    assign o_frame_byte1 = r_res0.frame_byte1;
    assign o_frame_byte2 = r_res0.frame_byte2;
    assign o_frame_byte3 = r_res0.frame_byte3;
    assign o_wait_ms     = r_res0.wait_ms;
    assign o_read_data   = r_res0.read_data;
    assign o_last        = r_res0.last;

    // Buffer never holds more than two results
    `IMSQ_ASSERT_SAME(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3, "result count overflow")

    // The first of a buffered pair is never the final result
    `IMSQ_ASSERT_SAME(a_pair_head, i_clk, i_rst_n, r_cnt == 2'd2, !r_res0.last, "pair head marked last")

    // Any request other than an EEPROM byte or a reply ends polling
    `IMSQ_ASSERT_NEXT(a_poll_drop, i_clk, i_rst_n, in_acc && (i_action != ACT_EEPROM_BYTE) && (i_action != ACT_REPLY), !r_polling, "polling not dropped")

    // A lone result that leaves with no new request empties the buffer
    `IMSQ_ASSERT_NEXT(a_drain, i_clk, i_rst_n, out_acc && (r_cnt == 2'd1) && !in_acc, r_cnt == 2'd0, "buffer not drained")

endmodule
